[rtl/heap_build_engine_core_defines.svh]
// Assertion macros for the heap build engine.
`ifndef HEAP_BUILD_ENGINE_CORE_DEFINES_SVH
`define HEAP_BUILD_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define HBE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("heap build engine: assertion failed");

// Expression must never be true outside reset.
`define HBE_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("heap build engine: forbidden condition seen");

`else

`define HBE_ASSERT(label, clk, rst, prop)

`define HBE_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[rtl/hbe_pkg.sv]
package hbe_pkg;

   localparam int DEF_HEAP_CAPACITY = 64;
   localparam int DEF_DATA_WIDTH    = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SIFT_P,
      ST_SIFT_L,
      ST_SIFT_R,
      ST_SIFT_CMP,
      ST_SIFT_W,
      ST_EMIT_RD,
      ST_EMIT_LD
   } hbe_state_type;

   typedef struct packed {
      logic loading;
      logic sifting;
      logic emitting;
      logic store_write;
   } hbe_status_type;

endpackage

[rtl/hbe_if.sv]
interface hbe_req_if #(
   parameter int DATA_WIDTH = hbe_pkg::DEF_DATA_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] element_value;
   logic                         is_last;

   modport source (output valid, output element_value, output is_last, input ready);
   modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface hbe_rsp_if #(
   parameter int DATA_WIDTH = hbe_pkg::DEF_DATA_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] heap_value;
   logic                         heap_last;
   logic                         overflowed;

   modport source (output valid, output heap_value, output heap_last, output overflowed,
                   input ready);
   modport sink   (input valid, input heap_value, input heap_last, input overflowed,
                   output ready);
endinterface

[rtl/hbe_store.sv]
module hbe_store #(
   parameter int HEAP_CAPACITY = hbe_pkg::DEF_HEAP_CAPACITY,
   parameter int DATA_WIDTH    = hbe_pkg::DEF_DATA_WIDTH,
   localparam int AW           = $clog2(HEAP_CAPACITY)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [HEAP_CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hbe_ctrl.sv]
module hbe_ctrl #(
   parameter int HEAP_CAPACITY = hbe_pkg::DEF_HEAP_CAPACITY,
   parameter int DATA_WIDTH    = hbe_pkg::DEF_DATA_WIDTH,
   localparam int AW           = $clog2(HEAP_CAPACITY)
) (
   input  logic                   clock,
   input  logic                   reset,
   hbe_req_if.sink                req_chan,
   hbe_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  logic                   csr_write_data,
   output logic                   mem_wr_en,
   output logic [AW-1:0]          mem_wr_addr,
   output logic [DATA_WIDTH-1:0]  mem_wr_data,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]  mem_rd_data,
   output hbe_pkg::hbe_status_type status
);

   localparam logic [AW:0] CAP = (AW+1)'(HEAP_CAPACITY);

   hbe_pkg::hbe_state_type state_ff, state_in;

   logic [AW:0]           count_ff, count_in;
   logic                  drop_ff, drop_in;
   logic [AW-1:0]         build_ff, build_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         best_ff, best_in;
   logic [AW-1:0]         emit_ff, emit_in;
   logic [DATA_WIDTH-1:0] parent_ff, parent_in;
   logic [DATA_WIDTH-1:0] left_ff, left_in;
   logic                  rvalid_ff, rvalid_in;
   logic                  order_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   // true when a belongs above b in the selected order
   function automatic logic ranks_above(input logic [DATA_WIDTH-1:0] a,
                                        input logic [DATA_WIDTH-1:0] b,
                                        input logic                  max_heap);
      logic gt;
      logic lt;
      gt = $signed(a) > $signed(b);
      lt = $signed(a) < $signed(b);
      return max_heap ? gt : lt;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbe_pkg::ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         build_ff     <= '0;
         pos_ff       <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         build_ff     <= build_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            order_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      emit_ff      <= emit_in;
      parent_ff    <= parent_in;
      left_ff      <= left_in;
      rvalid_ff    <= rvalid_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_comb begin
      logic [AW:0]           count_v;
      logic [AW+1:0]         left_idx;
      logic [AW+1:0]         right_idx;
      logic [AW+1:0]         wleft_idx;
      logic [AW+1:0]         count_ext;
      logic                  sift_done;
      logic                  left_wins;
      logic                  right_wins;
      logic [DATA_WIDTH-1:0] cand;
      logic                  can_load;

      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      build_in     = build_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      emit_in      = emit_ff;
      parent_in    = parent_ff;
      left_in      = left_ff;
      rvalid_in    = rvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      mem_wr_en    = 1'b0;
      mem_wr_addr  = pos_ff;
      mem_wr_data  = parent_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = pos_ff;

      count_v   = count_ff;
      count_ext = {1'b0, count_ff};
      left_idx  = {1'b0, pos_ff, 1'b1};
      right_idx = left_idx + (AW+2)'(1);
      wleft_idx = {1'b0, best_ff, 1'b1};
      sift_done = 1'b0;
      left_wins = ranks_above(left_ff, parent_ff, order_ff);
      cand      = left_wins ? left_ff : parent_ff;
      right_wins = rvalid_ff && ranks_above(mem_rd_data, cand, order_ff);
      can_load  = !rsp_valid_ff || rsp_chan.ready;

      case (state_ff)
         hbe_pkg::ST_LOAD: begin
            if (req_chan.valid) begin
               if (count_ff < CAP) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[AW-1:0];
                  mem_wr_data = req_chan.element_value;
                  count_v     = count_ff + (AW+1)'(1);
               end else begin
                  drop_in = 1'b1;
               end
               count_in = count_v;
               if (req_chan.is_last) begin
                  build_in = AW'((count_v - (AW+1)'(1)) >> 1);
                  pos_in   = AW'((count_v - (AW+1)'(1)) >> 1);
                  state_in = hbe_pkg::ST_SIFT_P;
               end
            end
         end
         hbe_pkg::ST_SIFT_P: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_ff;
            state_in    = hbe_pkg::ST_SIFT_L;
         end
         hbe_pkg::ST_SIFT_L: begin
            parent_in = mem_rd_data;
            if (left_idx < count_ext) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = left_idx[AW-1:0];
               state_in    = hbe_pkg::ST_SIFT_R;
            end else begin
               sift_done = 1'b1;
            end
         end
         hbe_pkg::ST_SIFT_R: begin
            left_in = mem_rd_data;
            if (right_idx < count_ext) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = right_idx[AW-1:0];
               rvalid_in   = 1'b1;
            end else begin
               rvalid_in = 1'b0;
            end
            state_in = hbe_pkg::ST_SIFT_CMP;
         end
         hbe_pkg::ST_SIFT_CMP: begin
            // ties keep the parent, and the left child over the right
            if (right_wins) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data;
               best_in     = right_idx[AW-1:0];
               state_in    = hbe_pkg::ST_SIFT_W;
            end else if (left_wins) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = left_ff;
               best_in     = left_idx[AW-1:0];
               state_in    = hbe_pkg::ST_SIFT_W;
            end else begin
               sift_done = 1'b1;
            end
         end
         hbe_pkg::ST_SIFT_W: begin
            // sifted value drops into the child slot; parent_ff keeps it for the next level
            mem_wr_en   = 1'b1;
            mem_wr_addr = best_ff;
            mem_wr_data = parent_ff;
            pos_in      = best_ff;
            if (wleft_idx < count_ext) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = wleft_idx[AW-1:0];
               state_in    = hbe_pkg::ST_SIFT_R;
            end else begin
               sift_done = 1'b1;
            end
         end
         hbe_pkg::ST_EMIT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = emit_ff;
            state_in    = hbe_pkg::ST_EMIT_LD;
         end
         hbe_pkg::ST_EMIT_LD: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = mem_rd_data;
               rsp_last_in  = ({1'b0, emit_ff} + (AW+1)'(1)) == count_ff;
               rsp_ovf_in   = drop_ff;
               if (({1'b0, emit_ff} + (AW+1)'(1)) == count_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = hbe_pkg::ST_LOAD;
               end else begin
                  emit_in     = emit_ff + AW'(1);
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = emit_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = hbe_pkg::ST_LOAD;
         end
      endcase

      if (sift_done) begin
         if (build_ff == '0) begin
            emit_in  = '0;
            state_in = hbe_pkg::ST_EMIT_RD;
         end else begin
            build_in = build_ff - AW'(1);
            pos_in   = build_ff - AW'(1);
            state_in = hbe_pkg::ST_SIFT_P;
         end
      end
   end

   assign req_chan.ready      = (state_ff == hbe_pkg::ST_LOAD);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.heap_value = rsp_value_ff;
   assign rsp_chan.heap_last  = rsp_last_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;

   assign status.loading     = (state_ff == hbe_pkg::ST_LOAD);
   assign status.emitting    = (state_ff == hbe_pkg::ST_EMIT_RD) ||
                               (state_ff == hbe_pkg::ST_EMIT_LD);
   assign status.sifting     = !status.loading && !status.emitting;
   assign status.store_write = mem_wr_en;

endmodule

[rtl/heap_build_engine_core.sv]
// Heap build engine: loads a set of signed elements, turns it into a binary
// heap in place (bottom-up build) and streams the heap out in array order.
// req_chan carries element_value and is_last; elements are taken one per cycle
// while the engine is loading, up to HEAP_CAPACITY, and further ones are dropped
// and reported through overflowed on every result of that set. is_last starts
// the build; req_chan.ready stays low from then until the set has been read out.
// csr_write_data selects a min-heap (0) or a max-heap (1); write it while idle.
// Build: each node reads the parent, then the left and right children through the one
// read port of the element store, then compares; a swap adds a write-back step, and a
// further read and compare where the moved value still has a child.
// Readout: the first result is read from the store and loaded into the output register,
// then one per cycle from the registered store port, heap_last on the final element; a
// stall on rsp_chan holds the output register and the store read. Loading of
// the next set may start while the last result waits.
// Reset clears the count, the overflow flag, the mode and the output valid;
// the store itself is not cleared.
`include "heap_build_engine_core_defines.svh"

module heap_build_engine_core #(
   parameter int HEAP_CAPACITY = hbe_pkg::DEF_HEAP_CAPACITY,
   parameter int DATA_WIDTH    = hbe_pkg::DEF_DATA_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   hbe_req_if.sink   req_chan,
   hbe_rsp_if.source rsp_chan,
   input  logic      csr_write_en,
   input  logic      csr_write_data
);

   localparam int AW = $clog2(HEAP_CAPACITY);

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [DATA_WIDTH-1:0]  mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [DATA_WIDTH-1:0]  mem_rd_data;
   hbe_pkg::hbe_status_type status;
   logic                   load_write;
   logic                   req_fire;

   hbe_store #(
      .HEAP_CAPACITY (HEAP_CAPACITY),
      .DATA_WIDTH    (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hbe_ctrl #(
      .HEAP_CAPACITY (HEAP_CAPACITY),
      .DATA_WIDTH    (DATA_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .status         (status)
   );

   assign load_write = status.loading && status.store_write;
   assign req_fire   = req_chan.valid && req_chan.ready;

   // readout must not disturb the store
   `HBE_ASSERT_NEVER(a_no_write_in_emit, clock, reset, status.emitting && status.store_write)
   // while loading, the store is written only by an accepted transaction
   `HBE_ASSERT(a_load_write_by_req, clock, reset, load_write |-> req_fire)
   // input is closed during build and readout
   `HBE_ASSERT(a_ready_only_loading, clock, reset, req_chan.ready |-> status.loading)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int CAP   = hbe_pkg::DEF_HEAP_CAPACITY;
   localparam int DW    = hbe_pkg::DEF_DATA_WIDTH;
   localparam int HOLD_CYCLES = 400;

   localparam logic ORDER_MIN = 1'b0;
   localparam logic ORDER_MAX = 1'b1;

   // value mixes for the stimulus
   typedef enum int {
      MIX_FULL,
      MIX_TIES,
      MIX_EXTREME
   } value_mix_type;

   typedef struct {
      logic signed [DW-1:0] value;
      logic                 last;
   } element_item_type;

   typedef struct {
      logic signed [DW-1:0] value;
      logic                 last;
      logic                 overflowed;
   } heap_entry_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   hbe_req_if #(.DATA_WIDTH(DW)) req_chan ();
   hbe_rsp_if #(.DATA_WIDTH(DW)) rsp_chan ();

   heap_build_engine_core #(
      .HEAP_CAPACITY(CAP),
      .DATA_WIDTH   (DW)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // pending transactions for the driver, expected heap entries for the monitor
   element_item_type     pending_q[$];
   heap_entry_type       heap_expect_q[$];

   // predictor state
   logic signed [DW-1:0] heap_store[CAP];
   int                   heap_count;
   logic                 heap_dropped;
   logic                 heap_max_mode;

   int                   err_count;
   int                   pushed_cnt;
   int                   accepted_cnt;
   int                   burst_left;
   int                   gap_left;
   int                   hold_left;
   logic                 hold_used;
   int                   stall_tick;
   int                   stall_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor ----------------

   function automatic logic outranks(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
      return heap_max_mode ? (a > b) : (a < b);
   endfunction

   task automatic sift_node(int start);
      int pos;
      int lc;
      int rc;
      int best;
      logic signed [DW-1:0] tmp;
      pos = start;
      forever begin
         lc   = 2 * pos + 1;
         rc   = lc + 1;
         best = pos;
         if (lc < heap_count && outranks(heap_store[lc], heap_store[best]))
            best = lc;
         if (rc < heap_count && outranks(heap_store[rc], heap_store[best]))
            best = rc;
         if (best == pos)
            break;
         tmp              = heap_store[best];
         heap_store[best] = heap_store[pos];
         heap_store[pos]  = tmp;
         pos              = best;
      end
   endtask

   task automatic absorb_element(logic signed [DW-1:0] value, logic last);
      heap_entry_type ent;
      if (heap_count < CAP) begin
         heap_store[heap_count] = value;
         heap_count++;
      end else begin
         heap_dropped = 1'b1;
      end
      if (last) begin
         for (int idx = (heap_count - 1) / 2; idx >= 0; idx--)
            sift_node(idx);
         for (int i = 0; i < heap_count; i++) begin
            ent.value      = heap_store[i];
            ent.last       = (i == heap_count - 1);
            ent.overflowed = heap_dropped;
            heap_expect_q.push_back(ent);
         end
         heap_count   = 0;
         heap_dropped = 1'b0;
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin : drive_proc
      element_item_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     <= $urandom_range(1, 16);
         gap_left       <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left > 0) begin
            req_chan.valid <= 1'b0;
            gap_left       <= gap_left - 1;
         end else if (pending_q.size() > 0) begin
            item = pending_q.pop_front();
            req_chan.valid         <= 1'b1;
            req_chan.element_value <= item.value;
            req_chan.is_last       <= item.last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------- receiver ----------------

   // one long hold-off once the run is well underway, so the engine backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && accepted_cnt >= 120) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end
   end

   always @(posedge clock) begin : ready_proc
      logic go;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_tick     <= 0;
         stall_mode     <= 0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 50 == 49)
            stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0:       go = 1'b1;
            1:       go = ($urandom_range(0, 1) == 0);
            2:       go = ($urandom_range(0, 3) == 0);
            default: go = (stall_tick % 4 != 3);
         endcase
         rsp_chan.ready <= go && (hold_left == 0);
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin : monitor_proc
      heap_entry_type exp_ent;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (heap_expect_q.size() == 0) begin
               $display("%0t: unexpected transaction, heap_value %0d heap_last %0b",
                        $time, rsp_chan.heap_value, rsp_chan.heap_last);
               err_count++;
            end else begin
               exp_ent = heap_expect_q.pop_front();
               if (rsp_chan.heap_value !== exp_ent.value) begin
                  $display("%0t: heap_value expected %0d actual %0d",
                           $time, exp_ent.value, rsp_chan.heap_value);
                  err_count++;
               end
               if (rsp_chan.heap_last !== exp_ent.last) begin
                  $display("%0t: heap_last expected %0b actual %0b",
                           $time, exp_ent.last, rsp_chan.heap_last);
                  err_count++;
               end
               if (rsp_chan.overflowed !== exp_ent.overflowed) begin
                  $display("%0t: overflowed expected %0b actual %0b",
                           $time, exp_ent.overflowed, rsp_chan.overflowed);
                  err_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            absorb_element(req_chan.element_value, req_chan.is_last);
            accepted_cnt <= accepted_cnt + 1;
         end
      end
   end

   // ---------------- stimulus ----------------

   function automatic logic signed [DW-1:0] pick_value(value_mix_type mix);
      logic signed [DW-1:0] v;
      case (mix)
         MIX_TIES: v = $signed($urandom_range(0, 8)) - 4;
         MIX_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       v = {1'b1, {(DW-1){1'b0}}};
               1:       v = {1'b0, {(DW-1){1'b1}}};
               2:       v = '0;
               3:       v = '1;
               default: v = 1;
            endcase
         end
         default: v = $signed($urandom());
      endcase
      return v;
   endfunction

   task automatic push_element(logic signed [DW-1:0] value, logic last);
      element_item_type item;
      item.value = value;
      item.last  = last;
      pending_q.push_back(item);
      pushed_cnt++;
   endtask

   task automatic queue_set(int n, value_mix_type mix);
      for (int i = 0; i < n; i++)
         push_element(pick_value(mix), i == n - 1);
   endtask

   task automatic write_order(logic order);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= order;
      heap_max_mode = order;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // every pushed transaction accepted and every heap entry seen
   task automatic drain();
      do @(negedge clock);
      while (accepted_cnt != pushed_cnt || heap_expect_q.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.element_value = '0;
      req_chan.is_last       = 1'b0;
      rsp_chan.ready         = 1'b0;
      err_count      = 0;
      pushed_cnt     = 0;
      accepted_cnt   = 0;
      heap_count     = 0;
      heap_dropped   = 1'b0;
      heap_max_mode  = ORDER_MIN;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: single-element set, extremes with ties, all-equal set
      write_order(ORDER_MIN);
      @(negedge clock);
      push_element({1'b1, {(DW-1){1'b0}}}, 1'b1);
      push_element({1'b0, {(DW-1){1'b1}}}, 1'b0);
      push_element({1'b1, {(DW-1){1'b0}}}, 1'b0);
      push_element(0, 1'b0);
      push_element(-1, 1'b0);
      push_element(1, 1'b0);
      push_element(5, 1'b0);
      push_element(5, 1'b0);
      push_element(5, 1'b1);
      drain();

      write_order(ORDER_MAX);
      @(negedge clock);
      push_element(-7, 1'b0);
      push_element({1'b1, {(DW-1){1'b0}}}, 1'b0);
      push_element(3, 1'b0);
      push_element(3, 1'b0);
      push_element({1'b0, {(DW-1){1'b1}}}, 1'b0);
      push_element(-1, 1'b0);
      push_element(0, 1'b0);
      push_element(3, 1'b1);
      push_element(42, 1'b0);
      push_element(42, 1'b0);
      push_element(42, 1'b1);
      drain();

      // random phases, min then max heap order and random after that; one full set and one overflowing set
      for (int p = 0; p < 6; p++) begin : rand_phase
         int phase_items;
         int n;
         write_order((p == 0) ? ORDER_MIN : (p == 1) ? ORDER_MAX : logic'($urandom_range(0, 1)));
         @(negedge clock);
         phase_items = 0;
         while (phase_items < 12) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            queue_set(n, value_mix_type'($urandom_range(0, 2)));
            phase_items += n;
         end
         if (p == 2)
            queue_set(CAP, MIX_FULL);
         if (p == 4)
            queue_set(CAP + 3, MIX_TIES);
         drain();
      end

      repeat (50) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
